>>> rtl/b64c_pkg.sv
// ----------------------------------------------------------------------------
// b64c_pkg: shared types, constants and alphabet functions
// Base64 character mapping, state and result-list types for the stream codec.
// ----------------------------------------------------------------------------
package b64c_pkg;

  localparam logic [6:0] LineChars = 7'd64;
  localparam int         MaxRes    = 5;
  localparam int         MaxChars  = 4;

  localparam logic [7:0] CharPad   = 8'h3D;  // '='
  localparam logic [7:0] CharNl    = 8'h0A;  // '\n'

  localparam logic       DirEncode = 1'b0;

  typedef struct packed {
    logic [11:0] acc;
    logic [3:0]  cnt;
    logic [6:0]  lc;
    logic        pad;
  } b64c_state_t;

  typedef struct packed {
    logic [MaxRes-1:0][7:0] data;
    logic [2:0]             num;
    logic                   marker;
  } b64c_res_t;

  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    logic [7:0] c;
    c = {2'b00, idx};
    if (idx < 6'd26) begin
      b64_char = 8'h41 + c;
    end else if (idx < 6'd52) begin
      b64_char = 8'h61 + c - 8'd26;
    end else if (idx < 6'd62) begin
      b64_char = 8'h30 + c - 8'd52;
    end else if (idx == 6'd62) begin
      b64_char = 8'h2B;
    end else begin
      b64_char = 8'h2F;
    end
  endfunction

  // {hit, index}
  function automatic logic [6:0] b64_index(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    b64_index = 7'h00;
    if (c inside {[8'h41:8'h5A]}) begin
      t = c - 8'h41;
      b64_index = {1'b1, t[5:0]};
    end else if (c inside {[8'h61:8'h7A]}) begin
      t = c - 8'h61 + 8'd26;
      b64_index = {1'b1, t[5:0]};
    end else if (c inside {[8'h30:8'h39]}) begin
      t = c - 8'h30 + 8'd52;
      b64_index = {1'b1, t[5:0]};
    end else if (c == 8'h2B) begin
      b64_index = {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      b64_index = {1'b1, 6'd63};
    end
  endfunction

endpackage

>>> rtl/b64c_core.sv
// ----------------------------------------------------------------------------
// b64c_core: per-item encode/decode step
// Computes the result list and next codec state for one accepted item.
// ----------------------------------------------------------------------------
module b64c_core (
  input  logic                 dir_i,
  input  b64c_pkg::b64c_state_t st_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 in_last_i,
  output b64c_pkg::b64c_state_t st_o,
  output b64c_pkg::b64c_res_t  res_o
);
  import b64c_pkg::*;

  logic [11:0]                acc_n;
  logic [3:0]                 cnt_n;
  logic [3:0]                 cnt_r;
  logic [MaxChars-1:0][7:0]   chars;
  logic [2:0]                 nch;
  logic [2:0]                 o;
  logic [6:0]                 lc;
  logic [6:0]                 dec;

  assign dec = b64_index(in_byte_i);

  always_comb begin
    st_o  = st_i;
    res_o = '0;
    acc_n = '0;
    cnt_n = '0;
    cnt_r = '0;
    chars = '0;
    nch   = '0;
    o     = '0;
    lc    = st_i.lc;
    if (dir_i == DirEncode) begin
      acc_n = {st_i.acc[3:0], in_byte_i};
      cnt_n = st_i.cnt + 4'd8;
      if (cnt_n == 4'd12) begin
        chars[0] = b64_char(acc_n[11:6]);
        chars[1] = b64_char(acc_n[5:0]);
        nch      = 3'd2;
        cnt_r    = 4'd0;
      end else if (cnt_n == 4'd10) begin
        chars[0] = b64_char(acc_n[9:4]);
        nch      = 3'd1;
        cnt_r    = 4'd4;
      end else begin
        chars[0] = b64_char(acc_n[7:2]);
        nch      = 3'd1;
        cnt_r    = 4'd2;
      end
      // tail: zero-filled last char plus padding, when bits remain
      if (in_last_i) begin
        if (cnt_r == 4'd2) begin
          chars[1] = b64_char({acc_n[1:0], 4'b0000});
          chars[2] = CharPad;
          chars[3] = CharPad;
          nch      = 3'd4;
        end else if (cnt_r == 4'd4) begin
          chars[1] = b64_char({acc_n[3:0], 2'b00});
          chars[2] = CharPad;
          nch      = 3'd3;
        end
      end
      // line breaks go out ahead of the char that overflows the line
      for (int i = 0; i < MaxChars; i++) begin
        if (3'(i) < nch) begin
          if (lc >= LineChars) begin
            res_o.data[o] = CharNl;
            o  = o + 3'd1;
            lc = 7'd0;
          end
          res_o.data[o] = chars[i];
          o  = o + 3'd1;
          lc = lc + 7'd1;
        end
      end
      res_o.num = o;
      st_o.acc  = acc_n;
      st_o.cnt  = cnt_r;
      st_o.lc   = lc;
    end else begin
      if (in_byte_i == CharPad) begin
        st_o.pad = 1'b1;
      end else if (!st_i.pad && dec[6]) begin
        acc_n    = {st_i.acc[5:0], dec[5:0]};
        cnt_n    = st_i.cnt + 4'd6;
        st_o.acc = acc_n;
        st_o.cnt = cnt_n;
        if (cnt_n >= 4'd8) begin
          cnt_r     = cnt_n - 4'd8;
          st_o.cnt  = cnt_r;
          res_o.num = 3'd1;
          case (cnt_r)
            4'd0:    res_o.data[0] = acc_n[7:0];
            4'd2:    res_o.data[0] = acc_n[9:2];
            default: res_o.data[0] = acc_n[11:4];
          endcase
        end
      end
    end
    if (in_last_i) begin
      st_o = '0;
      if (res_o.num == 3'd0) begin
        res_o.num    = 3'd1;
        res_o.marker = 1'b1;
      end
    end
  end

endmodule

>>> rtl/base64_stream_codec.sv
// ----------------------------------------------------------------------------
// base64_stream_codec: streaming Base64 encoder/decoder
// Top level: state registers, result list, output register and handshakes.
// ----------------------------------------------------------------------------
// Results leave at one per cycle unless m_axis_tready_i stalls them. An
// item is taken in the same cycle its predecessor's final result moves to
// the output register; each item yields n results (0..5), all through the
// single output port. Direction is set by cfg_we_i/cfg_wdata_i (0 encode,
// 1 decode) between messages; a write clears the message state. In encode
// mode a newline is inserted after every 64 characters but never at the
// end. The item marked tlast yields a result with tlast set; when no byte
// is due that result has tuser low and tdata zero.
module base64_stream_codec (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,     // direction
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] in_byte
  input  logic       s_axis_tlast_i,  // in_last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] out_byte
  output logic       m_axis_tuser_o,  // [0] out_valid
  output logic       m_axis_tlast_o   // out_last
);
  import b64c_pkg::*;

  logic                   dir_q;
  b64c_state_t            st_q, st_d;
  b64c_res_t              res;

  logic [MaxRes-1:0][7:0] pend_q, pend_d;
  logic [2:0]             pend_cnt_q, pend_cnt_d;
  logic                   pend_last_q, pend_last_d;
  logic                   pend_mark_q, pend_mark_d;

  logic                   out_vld_q;
  logic [7:0]             out_byte_q;
  logic                   out_valid_q;
  logic                   out_last_q;

  logic                   move;
  logic                   accept;

  b64c_core u_core (
    .dir_i     (dir_q),
    .st_i      (st_q),
    .in_byte_i (s_axis_tdata_i),
    .in_last_i (s_axis_tlast_i),
    .st_o      (st_d),
    .res_o     (res)
  );

  assign move   = (pend_cnt_q != 3'd0) && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = (pend_cnt_q == 3'd0) || ((pend_cnt_q == 3'd1) && move);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    pend_d      = pend_q;
    pend_cnt_d  = pend_cnt_q;
    pend_last_d = pend_last_q;
    pend_mark_d = pend_mark_q;
    if (move) begin
      for (int i = 0; i < MaxRes - 1; i++) begin
        pend_d[i] = pend_q[i+1];
      end
      pend_cnt_d = pend_cnt_q - 3'd1;
    end
    if (accept) begin
      pend_d      = res.data;
      pend_cnt_d  = res.num;
      pend_last_d = s_axis_tlast_i;
      pend_mark_d = res.marker;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q       <= 1'b0;
      st_q        <= '0;
      pend_cnt_q  <= '0;
      pend_last_q <= 1'b0;
      pend_mark_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dir_q <= cfg_wdata_i;
        st_q  <= '0;
      end else if (accept) begin
        st_q  <= st_d;
      end
      pend_cnt_q  <= pend_cnt_d;
      pend_last_q <= pend_last_d;
      pend_mark_q <= pend_mark_d;
      if (move) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (move) begin
      out_byte_q  <= pend_q[0];
      out_valid_q <= !pend_mark_q;
      out_last_q  <= pend_last_q && (pend_cnt_q == 3'd1);
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tuser_o  = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_cnt_q <= 3'(MaxRes))
    else $error("result list overflow");

  a_accept_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> (pend_cnt_q == 3'd0) || (pend_cnt_q == 3'd1 && move))
    else $error("item taken while results pending");

  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tlast_o && m_axis_tdata_o == 8'h00))
    else $error("marker result not last or not zero");

  a_marker_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_mark_q && pend_cnt_q != 3'd0) |-> (pend_cnt_q == 3'd1 && pend_last_q))
    else $error("marker shares list with data");

endmodule
